[hdl/htd_pkg.sv]
package htd_pkg;

	// Size of the node store and the longest code that an add may carry.
	localparam int MAX_NODES       = 1024;
	localparam int MAX_CODE_LENGTH = 32;

	localparam int NODE_AW = $clog2(MAX_NODES);
	localparam int USED_W  = $clog2(MAX_NODES + 1);

	// Fixed field widths of the channels.
	localparam int CMD_W     = 2;
	localparam int SYM_W     = 16;
	localparam int LEN_W     = 6;
	localparam int CODE_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int STATUS_W  = 3;
	localparam int OUT_SYM_W = 8;

	localparam int CODE_IW = $clog2(CODE_W);
	localparam int BYTE_IW = $clog2(BYTE_W);

	localparam logic [SYM_W-1:0] END_CODE_RST = SYM_W'(256);

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_BYTE   = 2'd2,
		CMD_FINISH = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_SYMBOL  = 3'd0,
		ST_END     = 3'd1,
		ST_INVALID = 3'd2,
		ST_NO_END  = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	// One tree node; a child index of zero means no child.
	typedef struct packed {
		logic [NODE_AW-1:0]   child1;
		logic [NODE_AW-1:0]   child0;
		logic                 term;
		logic                 is_end;
		logic [OUT_SYM_W-1:0] sym;
	} node_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    clear;
		logic    descend;
		logic    rd_root;
		logic    alloc;
		logic    wr_fin;
		logic    wr_back;
		logic    save_walk;
		logic    stop;
		logic    emit;
		status_t emit_status;
		logic    flush;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t in_cmd;
		logic len_ok;
		logic stopped;
		logic rem_zero;
		logic chk;
		logic term;
		logic is_end;
		logic child_zero;
		logic full;
		logic pend_valid;
		logic can_push;
	} dp_stat_t;

endpackage

[hdl/htd_ifs.sv]
interface htd_in_if import htd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SYM_W-1:0]  symbol;
	logic [LEN_W-1:0]  code_length;
	logic [CODE_W-1:0] code_word;
	logic [BYTE_W-1:0] payload_byte;

	modport source (output valid, command, symbol, code_length, code_word, payload_byte,
		input ready);
	modport sink (input valid, command, symbol, code_length, code_word, payload_byte,
		output ready);
endinterface

interface htd_out_if import htd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [OUT_SYM_W-1:0] symbol_value;
	logic                 last;

	modport source (output valid, status, symbol_value, last, input ready);
	modport sink (input valid, status, symbol_value, last, output ready);
endinterface

interface htd_cfg_if import htd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[hdl/htd_datapath.sv]
module htd_datapath import htd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CMD_W-1:0]     command,
	input  logic [SYM_W-1:0]     symbol,
	input  logic [LEN_W-1:0]     code_length,
	input  logic [CODE_W-1:0]    code_word,
	input  logic [BYTE_W-1:0]    payload_byte,
	input  logic                 cfg_valid,
	input  logic [SYM_W-1:0]     cfg_data,
	input  logic                 out_ready,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output logic                 out_valid,
	output logic [STATUS_W-1:0]  out_status,
	output logic [OUT_SYM_W-1:0] out_symbol,
	output logic                 out_last
);

	node_t              mem [MAX_NODES];
	node_t              rd_q;
	node_t              content;
	node_t              wr_data;
	logic               wr_en;
	logic [NODE_AW-1:0] wr_addr;
	logic               rd_en;
	logic [NODE_AW-1:0] rd_addr;

	cmd_t               cmd_q;
	logic [SYM_W-1:0]   sym_q;
	logic [CODE_W-1:0]  code_q;
	logic [BYTE_W-1:0]  byte_q;
	logic [SYM_W-1:0]   end_code_q;
	logic [NODE_AW-1:0] cur_idx_q;
	logic [LEN_W-1:0]   rem_q;
	logic [LEN_W-1:0]   rem_m1;
	logic               fresh_q;
	logic               chk_q;
	logic [USED_W-1:0]  used_q;
	logic [NODE_AW-1:0] walk_q;
	logic               stopped_q;
	logic               cur_bit;
	logic [NODE_AW-1:0] child;
	logic               full;

	logic                 pend_valid_q;
	status_t              pend_status_q;
	logic [OUT_SYM_W-1:0] pend_sym_q;
	logic                 push;
	logic                 can_push;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [OUT_SYM_W-1:0] out_symbol_q;
	logic                 out_last_q;

	// A freshly allocated node is known to be empty and is not read back.
	assign content = fresh_q ? '0 : rd_q;
	assign rem_m1  = rem_q - LEN_W'(1);
	assign cur_bit = (cmd_q == CMD_ADD) ? code_q[rem_m1[CODE_IW-1:0]]
	                                    : byte_q[rem_m1[BYTE_IW-1:0]];
	assign child   = cur_bit ? content.child1 : content.child0;
	assign full    = (used_q >= USED_W'(MAX_NODES));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_idx_q;
		wr_data = content;
		if (cmd.clear) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = '0;
		end else if (cmd.alloc) begin
			wr_en = 1'b1;
			if (cur_bit) begin
				wr_data.child1 = used_q[NODE_AW-1:0];
			end else begin
				wr_data.child0 = used_q[NODE_AW-1:0];
			end
		end else if (cmd.wr_fin) begin
			wr_en          = 1'b1;
			wr_data.term   = 1'b1;
			wr_data.is_end = (sym_q == end_code_q);
			wr_data.sym    = sym_q[OUT_SYM_W-1:0];
		end else if (cmd.wr_back) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		rd_en   = cmd.load | cmd.descend | cmd.rd_root;
		rd_addr = '0;
		if (cmd.load && (cmd_t'(command) == CMD_BYTE)) begin
			rd_addr = walk_q;
		end else if (cmd.descend) begin
			rd_addr = child;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Item fields and walk context.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= cmd_t'(command);
			sym_q     <= symbol;
			code_q    <= code_word;
			byte_q    <= payload_byte;
			cur_idx_q <= (cmd_t'(command) == CMD_BYTE) ? walk_q : '0;
			rem_q     <= (cmd_t'(command) == CMD_BYTE) ? LEN_W'(BYTE_W) : code_length;
			fresh_q   <= 1'b0;
			chk_q     <= 1'b0;
		end else if (cmd.descend) begin
			cur_idx_q <= child;
			rem_q     <= rem_m1;
			fresh_q   <= 1'b0;
			chk_q     <= 1'b1;
		end else if (cmd.rd_root) begin
			cur_idx_q <= '0;
			fresh_q   <= 1'b0;
			chk_q     <= 1'b0;
		end else if (cmd.alloc) begin
			cur_idx_q <= used_q[NODE_AW-1:0];
			rem_q     <= rem_m1;
			fresh_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_code_q <= END_CODE_RST;
			used_q     <= USED_W'(1);
			walk_q     <= '0;
			stopped_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				end_code_q <= cfg_data;
			end
			if (cmd.clear) begin
				used_q    <= USED_W'(1);
				walk_q    <= '0;
				stopped_q <= 1'b0;
			end else begin
				if (cmd.alloc) begin
					used_q <= used_q + USED_W'(1);
				end
				if (cmd.save_walk) begin
					walk_q <= cur_idx_q;
				end
				if (cmd.stop) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	// A result waits in the hold register until the next one, or the end of
	// the item, shows whether it is the last.
	assign can_push = !out_valid_q || out_ready;
	assign push     = (cmd.emit && pend_valid_q) || cmd.flush;

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_status_q <= cmd.emit_status;
			pend_sym_q    <= (cmd.emit_status == ST_SYMBOL) ? content.sym : '0;
		end
		if (push) begin
			out_status_q <= pend_status_q;
			out_symbol_q <= pend_sym_q;
			out_last_q   <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.emit) begin
				pend_valid_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_symbol = out_symbol_q;
	assign out_last   = out_last_q;

	always_comb begin
		stat.in_cmd     = cmd_t'(command);
		stat.len_ok     = (code_length != '0) && (code_length <= LEN_W'(MAX_CODE_LENGTH));
		stat.stopped    = stopped_q;
		stat.rem_zero   = (rem_q == '0);
		stat.chk        = chk_q;
		stat.term       = content.term;
		stat.is_end     = content.is_end;
		stat.child_zero = (child == '0);
		stat.full       = full;
		stat.pend_valid = pend_valid_q;
		stat.can_push   = can_push;
	end

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != '0) && (used_q <= USED_W'(MAX_NODES)))
		else $error("node count out of range");

	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !full)
		else $error("node allocated in a full store");

	a_flush_pending: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> pend_valid_q)
		else $error("flush with no held result");

endmodule

[hdl/htd_ctrl.sv]
module htd_ctrl import htd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  dp_stat_t stat,
	output logic     in_ready,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ADD   = 4'b0010,
		S_DEC   = 4'b0100,
		S_FLUSH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					case (stat.in_cmd)
						CMD_CLEAR: begin
							cmd.clear = 1'b1;
						end
						CMD_ADD: begin
							if (stat.len_ok) begin
								state_d = S_ADD;
							end
						end
						CMD_BYTE: begin
							if (!stat.stopped) begin
								state_d = S_DEC;
							end
						end
						default: begin
							if (!stat.stopped) begin
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_NO_END;
								cmd.stop        = 1'b1;
								state_d         = S_FLUSH;
							end
						end
					endcase
				end
			end
			S_ADD: begin
				if (stat.rem_zero) begin
					cmd.wr_fin = 1'b1;
					state_d    = S_IDLE;
				end else if (!stat.child_zero) begin
					cmd.descend = 1'b1;
				end else if (stat.full) begin
					// Keep a node allocated by this entry consistent in the store.
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_FULL;
					cmd.wr_back     = 1'b1;
					state_d         = S_FLUSH;
				end else begin
					cmd.alloc = 1'b1;
				end
			end
			S_DEC: begin
				if (!stat.pend_valid || stat.can_push) begin
					if (stat.chk && stat.term) begin
						cmd.emit = 1'b1;
						if (stat.is_end) begin
							cmd.emit_status = ST_END;
							cmd.stop        = 1'b1;
							state_d         = S_FLUSH;
						end else begin
							cmd.emit_status = ST_SYMBOL;
							cmd.rd_root     = 1'b1;
						end
					end else if (stat.rem_zero) begin
						cmd.save_walk = 1'b1;
						state_d       = S_FLUSH;
					end else if (stat.child_zero) begin
						cmd.emit        = 1'b1;
						cmd.emit_status = ST_INVALID;
						cmd.stop        = 1'b1;
						state_d         = S_FLUSH;
					end else begin
						cmd.descend = 1'b1;
					end
				end
			end
			S_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.can_push) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !stat.pend_valid)
		else $error("result left held after an item");

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!stat.pend_valid || stat.can_push))
		else $error("result emitted with no room to move the held one");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");

endmodule

[hdl/huffman_tree_decoder.sv]
// Huffman tree decoder. Input items either clear the code tree (no result),
// add a code entry (after acceptance it descends to or allocates a node for
// each code bit and then marks the final node; no result unless the node
// store is full), deliver one payload byte, or signal the end of the payload.
// A payload byte walks its eight bits MSB first through the tree. When it walks
// all eight bits it makes one node-store read per bit and one extra read of the
// root after each decoded symbol, then tests the node where the byte ends, and
// then hands off the final result. A byte that meets the end marker or a missing
// child finishes sooner. The walk is paced by the single node-store read port,
// whose registered data feeds the next bit's child lookup. Each result waits in
// a hold register so that last can be set on the final result of its input
// item; results then leave through an output register. While a result is held
// and the output register is still full, the walk waits until the consumer
// takes a transfer. The end_code register can be written at any time the block
// is idle and is used when a code entry marks its node. The node store is not
// cleared after reset: send a clear command before the first code entry.
module huffman_tree_decoder import htd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	htd_in_if.sink   in_ch,
	htd_out_if.source out_ch,
	htd_cfg_if.sink  cfg
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The end-code register accepts a transfer in every cycle.
	assign cfg.ready = 1'b1;

	htd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.stat     (stat),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	htd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (in_ch.command),
		.symbol       (in_ch.symbol),
		.code_length  (in_ch.code_length),
		.code_word    (in_ch.code_word),
		.payload_byte (in_ch.payload_byte),
		.cfg_valid    (cfg.valid),
		.cfg_data     (cfg.data),
		.out_ready    (out_ch.ready),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_ch.valid),
		.out_status   (out_ch.status),
		.out_symbol   (out_ch.symbol_value),
		.out_last     (out_ch.last)
	);

endmodule

[dv/huffman_tree_decoder_tb.sv]
`timescale 1ns / 100ps

module huffman_tree_decoder_tb import htd_pkg::*; ();

	// Period of the clock is 20 ns, so each half is 10 ns.
	localparam int HALF_PERIOD    = 10;
	// About this many items in the random part.
	localparam int RANDOM_ITEMS   = 400;
	// Cycles let pass after the last result before a register write or the
	// end of the run. An add may still be in flight then; it gives no result.
	localparam int DRAIN_CYCLES   = 50;
	// Length of the long stretch in which the result side holds off.
	localparam int HOLD_CYCLES    = 200;
	// The run fails when no transfer of any kind happens for this long.
	localparam int WATCHDOG_LIMIT = 4000;

	// One input item as the sender offers it.
	typedef struct {
		cmd_t                command;
		logic [SYM_W-1:0]    symbol;
		logic [LEN_W-1:0]    code_length;
		logic [CODE_W-1:0]   code_word;
		logic [BYTE_W-1:0]   payload_byte;
	} htd_item_t;

	// One result as the block should deliver it.
	typedef struct {
		status_t              status;
		logic [OUT_SYM_W-1:0] symbol_value;
		logic                 last;
	} htd_result_t;

	// The scoreboard keeps its own copy of the code tree and of the decoder's
	// walk state. Every accepted item is played against that copy and the
	// results it should cause are queued in order. Every delivered result is
	// then checked against the oldest one in the queue.
	class decode_scoreboard;
		logic [NODE_AW-1:0]   kid0 [MAX_NODES];
		logic [NODE_AW-1:0]   kid1 [MAX_NODES];
		logic                 is_term [MAX_NODES];
		logic                 is_eob [MAX_NODES];
		logic [OUT_SYM_W-1:0] leaf_sym [MAX_NODES];
		int unsigned          nodes_taken;
		int unsigned          cursor;
		bit                   halted;
		logic [SYM_W-1:0]     eob_code;
		htd_result_t          expected_q [$];
		int                   errors;

		function new();
			nodes_taken = 1;
			cursor      = 0;
			halted      = 0;
			eob_code    = END_CODE_RST;
			errors      = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void clear_node(int unsigned idx);
			kid0[idx]     = '0;
			kid1[idx]     = '0;
			is_term[idx]  = 1'b0;
			is_eob[idx]   = 1'b0;
			leaf_sym[idx] = '0;
		endfunction

		function void push_result(status_t st, logic [OUT_SYM_W-1:0] s);
			htd_result_t r;
			r.status       = st;
			r.symbol_value = s;
			r.last         = 1'b0;
			expected_q.push_back(r);
		endfunction

		function void note_item(htd_item_t it);
			int unsigned before_n;
			int unsigned node;
			int unsigned nxt;
			int          b;
			bit          bit_v;
			bit          halt_walk;
			before_n  = expected_q.size();
			halt_walk = 0;
			case (it.command)
				CMD_CLEAR: begin
					clear_node(0);
					nodes_taken = 1;
					cursor      = 0;
					halted      = 0;
				end
				CMD_ADD: begin
					// Lengths of zero or beyond the longest code leave the tree alone.
					if (it.code_length != 0 && it.code_length <= MAX_CODE_LENGTH) begin
						node = 0;
						b    = int'(it.code_length) - 1;
						while (b >= 0 && !halt_walk) begin
							bit_v = it.code_word[b];
							nxt   = 32'(bit_v ? kid1[node] : kid0[node]);
							if (nxt == 0) begin
								// A missing child is allocated unless the store is full;
								// nodes taken so far by this entry stay in the tree.
								if (nodes_taken >= MAX_NODES) begin
									push_result(ST_FULL, '0);
									halt_walk = 1;
								end else begin
									nxt = nodes_taken;
									nodes_taken++;
									clear_node(nxt);
									if (bit_v)
										kid1[node] = NODE_AW'(nxt);
									else
										kid0[node] = NODE_AW'(nxt);
								end
							end
							node = nxt;
							b--;
						end
						if (!halt_walk) begin
							is_term[node]  = 1'b1;
							is_eob[node]   = (it.symbol == eob_code);
							leaf_sym[node] = it.symbol[OUT_SYM_W-1:0];
						end
					end
				end
				CMD_BYTE: begin
					if (!halted) begin
						node = cursor;
						b    = BYTE_W - 1;
						while (b >= 0 && !halt_walk) begin
							nxt = 32'(it.payload_byte[b] ? kid1[node] : kid0[node]);
							if (nxt == 0) begin
								push_result(ST_INVALID, '0);
								halted    = 1;
								halt_walk = 1;
							end else begin
								node = nxt;
								if (is_term[node]) begin
									if (is_eob[node]) begin
										push_result(ST_END, '0);
										halted    = 1;
										halt_walk = 1;
									end else begin
										push_result(ST_SYMBOL, leaf_sym[node]);
										node = 0;
									end
								end
							end
							b--;
						end
						cursor = node;
					end
				end
				default: begin
					if (!halted) begin
						push_result(ST_NO_END, '0);
						halted = 1;
					end
				end
			endcase
			if (expected_q.size() > before_n)
				expected_q[expected_q.size() - 1].last = 1'b1;
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [OUT_SYM_W-1:0] s, logic l);
			htd_result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: status %0d, symbol_value 0x%0h, last %0b", st, s, l);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				errors++;
			end
			if (s !== want.symbol_value) begin
				$error("symbol_value: expected 0x%0h, got 0x%0h", want.symbol_value, s);
				errors++;
			end
			if (l !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, l);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	htd_in_if  in_if ();
	htd_out_if out_if ();
	htd_cfg_if cfg_if ();

	huffman_tree_decoder DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if),
		.cfg    (cfg_if)
	);

	decode_scoreboard sb;

	// Switches that shape the traffic of the current phase. With idling off,
	// a side runs back to back. The sender raises the request count to ask the
	// result side for one long stall while it keeps pushing payload bytes; the
	// result side keeps its own count of the stalls it has served.
	bit          tx_idle_on;
	bit          rx_idle_on;
	int unsigned hold_requests;
	int unsigned holds_served;
	bit          counting;
	int unsigned random_items;
	int unsigned quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Most gaps are short; now and then one is long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!tx_idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one item and waits for its transfer. Inputs change on the falling
	// edge only, and the ready seen right after the rising edge is the value
	// the block sampled at that edge. Valid stays high after the transfer, so
	// a following item with no gap goes out back to back. Field values arrive
	// as 32 bits and are cut to the width of their field here.
	task automatic send_item(cmd_t c, logic [31:0] s, logic [31:0] l, logic [31:0] w,
		logic [31:0] b);
		htd_item_t   it;
		int unsigned gap;
		it.command      = c;
		it.symbol       = s[SYM_W-1:0];
		it.code_length  = l[LEN_W-1:0];
		it.code_word    = w[CODE_W-1:0];
		it.payload_byte = b[BYTE_W-1:0];
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_if.valid        = 1'b1;
		in_if.command      = it.command;
		in_if.symbol       = it.symbol;
		in_if.code_length  = it.code_length;
		in_if.code_word    = it.code_word;
		in_if.payload_byte = it.payload_byte;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		sb.note_item(it);
		// Adds that the block drops without a trace do not count.
		if (counting && !(c == CMD_ADD
			&& (it.code_length == 0 || it.code_length > MAX_CODE_LENGTH)))
			random_items++;
	endtask

	// Stops offering, waits for every queued result, then lets the block
	// finish any add still in flight, which gives no result of its own.
	task automatic settle();
		@(negedge clk);
		in_if.valid = 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Writes end_code; only ever called while the block is idle.
	task automatic write_end_code(logic [SYM_W-1:0] v);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.data  = v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		sb.eob_code = v;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// Builds a random complete prefix code by splitting leaves, loads it in a
	// random order and decodes random bytes with it. Since every path ends in
	// a leaf, decoding runs on until the end marker is met, unless one entry
	// is left out on purpose so that a missing child shows up. A phase that
	// squeezes the result side keeps the code complete and without an end
	// marker, so decoding goes on producing results during the long stall.
	task automatic run_code_phase(bit squeeze);
		int unsigned       leaf_len [$];
		logic [CODE_W-1:0] leaf_code [$];
		int unsigned       n_leaves;
		int unsigned       pick;
		int unsigned       n_bytes;
		logic [31:0]       sym;
		bit                with_eob;
		n_leaves  = $urandom_range(2, 16);
		leaf_len  = {1, 1};
		leaf_code = {32'd0, 32'd1};
		while (leaf_len.size() < n_leaves) begin
			pick = $urandom_range(0, leaf_len.size() - 1);
			if (leaf_len[pick] < 9) begin
				leaf_len.push_back(leaf_len[pick] + 1);
				leaf_code.push_back({leaf_code[pick][CODE_W-2:0], 1'b1});
				leaf_len[pick]++;
				leaf_code[pick] = leaf_code[pick] << 1;
			end
		end
		with_eob = !squeeze && ($urandom_range(0, 2) == 0);
		if (!squeeze && $urandom_range(0, 4) == 0) begin
			pick = $urandom_range(0, leaf_len.size() - 1);
			leaf_len.delete(pick);
			leaf_code.delete(pick);
		end
		send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		while (leaf_len.size() > 0) begin
			pick = $urandom_range(0, leaf_len.size() - 1);
			sym  = $urandom;
			// The first entry loaded carries the end marker when one is wanted;
			// the order is random, so the marker lands on any code length.
			if (with_eob) begin
				sym      = 32'(sb.eob_code);
				with_eob = 0;
			end
			send_item(CMD_ADD, sym, leaf_len[pick], leaf_code[pick], $urandom);
			leaf_len.delete(pick);
			leaf_code.delete(pick);
		end
		if (squeeze)
			hold_requests++;
		n_bytes = squeeze ? 24 : $urandom_range(4, 20);
		repeat (n_bytes)
			send_item(CMD_BYTE, $urandom, $urandom, $urandom, $urandom);
		if ($urandom_range(0, 9) < 7)
			send_item(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Long random codes take a fresh branch on almost every add, so a few
	// dozen of them run the node store out of space.
	task automatic run_fill_phase();
		send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		repeat (48)
			send_item(CMD_ADD, $urandom, $urandom_range(20, MAX_CODE_LENGTH), $urandom, $urandom);
		repeat (6)
			send_item(CMD_BYTE, $urandom, $urandom, $urandom, $urandom);
		send_item(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
	endtask

	// Unstructured traffic: short overlapping codes, stray lengths, clears in
	// the middle of a payload and repeated ends of payload.
	task automatic run_noise_phase();
		int unsigned r;
		int unsigned len;
		send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		repeat ($urandom_range(10, 30)) begin
			r = $urandom_range(0, 9);
			if (r < 4) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 6);
				send_item(CMD_ADD, $urandom, len, $urandom, $urandom);
			end else if (r < 8) begin
				send_item(CMD_BYTE, $urandom, $urandom, $urandom, $urandom);
			end else if (r < 9) begin
				send_item(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
			end else begin
				send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	// Result side. Ready changes on the falling edge. A new hold request from
	// the stimulus turns into one long stall counted here, so the sender keeps
	// going while the block backs up.
	initial begin
		holds_served = 0;
		out_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				out_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (!rx_idle_on) begin
				out_if.ready = 1'b1;
			end else if ($urandom_range(0, 99) < 3) begin
				out_if.ready = 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end else begin
				out_if.ready = ($urandom_range(0, 99) >= 30);
			end
		end
	end

	// Each result transfer is checked at the edge where it happens.
	always @(posedge clk) begin
		if (arst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
			sb.check_result(out_if.status, out_if.symbol_value, out_if.last);
	end

	// The watchdog restarts on any transfer and ends a run that has hung.
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
			|| (cfg_if.valid && cfg_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int unsigned phase;
		int unsigned r;
		sb                 = new();
		arst_n             = 1'b0;
		in_if.valid        = 1'b0;
		in_if.command      = CMD_CLEAR;
		in_if.symbol       = '0;
		in_if.code_length  = '0;
		in_if.code_word    = '0;
		in_if.payload_byte = '0;
		cfg_if.valid       = 1'b0;
		cfg_if.data        = '0;
		tx_idle_on         = 1;
		rx_idle_on         = 1;
		hold_requests      = 0;
		counting           = 0;
		random_items       = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The directed part uses a small tree: 00, 01 and 10 are plain
		// symbols, 110 is symbol zero and 111 is the end marker.
		write_end_code(16'h0100);
		// The root is undefined until the first clear, so that comes first.
		send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		send_item(CMD_ADD, 'h0041, 2, 32'h0, $urandom);
		send_item(CMD_ADD, 'h00FF, 2, 32'h1, $urandom);
		send_item(CMD_ADD, 'h1234, 2, 32'h2, $urandom);
		send_item(CMD_ADD, 'h0000, 3, 32'h6, $urandom);
		send_item(CMD_ADD, 'h0100, 3, 32'h7, $urandom);
		// An empty code and codes longer than the tree allows change nothing.
		send_item(CMD_ADD, 'h0055, 0, 32'hFFFF_FFFF, $urandom);
		send_item(CMD_ADD, 'h0055, 33, 32'hFFFF_FFFF, $urandom);
		send_item(CMD_ADD, 'h0055, 63, 32'hFFFF_FFFF, $urandom);
		send_item(CMD_BYTE, $urandom, $urandom, $urandom, 'h00);
		// Loading the same code again replaces its symbol.
		send_item(CMD_ADD, 'h0042, 2, 32'h0, $urandom);
		// This byte leaves the walk part way down a three-bit code, and the
		// next one finishes it before running into the end marker.
		send_item(CMD_BYTE, $urandom, $urandom, $urandom, 'h1B);
		send_item(CMD_BYTE, $urandom, $urandom, $urandom, 'h3F);
		// Once stopped, bytes and the end of payload stay silent.
		send_item(CMD_BYTE, $urandom, $urandom, $urandom, 'h00);
		send_item(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
		// Two full-length codes; the payload ends with the walk mid-code,
		// which reports a missing end marker exactly once.
		send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		send_item(CMD_ADD, 'h0007, MAX_CODE_LENGTH, 32'hFFFF_FFFF, $urandom);
		send_item(CMD_ADD, 'hFFFF, MAX_CODE_LENGTH, 32'h0, $urandom);
		send_item(CMD_BYTE, $urandom, $urandom, $urandom, 'hFF);
		send_item(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
		send_item(CMD_FINISH, $urandom, $urandom, $urandom, $urandom);
		// Node 1 becomes a leaf that also has a child, so reaching it still
		// emits. A byte of zeros then yields the most results one item gives,
		// and a one after a decoded symbol hits a missing child.
		send_item(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
		send_item(CMD_ADD, 'h00AA, 2, 32'h1, $urandom);
		send_item(CMD_ADD, 'h0003, 1, 32'h0, $urandom);
		send_item(CMD_BYTE, $urandom, $urandom, $urandom, 'h00);
		send_item(CMD_BYTE, $urandom, $urandom, $urandom, 'h40);
		settle();

		// Random part. Each phase starts from an idle block, which is also
		// where end_code changes: both extremes early on, random values later.
		counting = 1;
		phase    = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase == 1)
				write_end_code(16'h0000);
			else if (phase == 2)
				write_end_code(16'hFFFF);
			else if (phase > 2 && $urandom_range(0, 2) == 0)
				write_end_code(SYM_W'($urandom));
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			r = $urandom_range(0, 11);
			if (phase == 0)
				run_code_phase(1);
			else if (phase == 1 || (phase > 2 && r == 0))
				run_fill_phase();
			else if (phase == 2 || r < 3)
				run_noise_phase();
			else
				run_code_phase(r == 3);
			settle();
			phase++;
		end

		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
hdl/htd_pkg.sv
hdl/htd_ifs.sv
hdl/htd_datapath.sv
hdl/htd_ctrl.sv
hdl/huffman_tree_decoder.sv
dv/huffman_tree_decoder_tb.sv
